// File: hw/rtl/median_filter_2d_macros.svh
`ifndef MEDIAN_FILTER_2D_MACROS_SVH
`define MEDIAN_FILTER_2D_MACROS_SVH

// same-cycle implication
`define MF2D_CHECK(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MF2D_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/mf2d_pkg.sv
package mf2d_pkg;

  localparam int MAX_RADIUS = 2;
  localparam int MAX_WIDTH  = 1024;
  localparam int RING_ROWS  = 2 * MAX_RADIUS + 1;
  localparam int WIN_MAX    = RING_ROWS * RING_ROWS;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int SLOT_W = $clog2(RING_ROWS);
  localparam int CELL_W = $clog2(WIN_MAX);

  localparam int PIX_W   = 8;
  localparam int RAD_W   = 2;
  localparam int COLS_W  = 11;
  localparam int ROWS_W  = 12;
  localparam int RC_W    = 13;
  localparam int IDX_W   = 14;
  localparam int CFG_W   = 12;
  localparam int CFGI_W  = 2;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  typedef enum logic [CFGI_W-1:0] {
    CFG_RADIUS_X,
    CFG_RADIUS_Y,
    CFG_IMAGE_COLS,
    CFG_IMAGE_ROWS
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic clr;
    logic ins;
  } sort_ctl_t;

  // reflect-101 with clamp for tiny images
  function automatic logic [RC_W-1:0] mirror(input logic signed [IDX_W-1:0] i,
                                             input logic [RC_W-1:0] n);
    logic signed [IDX_W-1:0] v;
    logic signed [IDX_W-1:0] ns;
    v  = i;
    ns = $signed({1'b0, n});
    if (v < $signed(IDX_W'(0))) v = -v;
    if (v >= ns) v = ns + ns - $signed(IDX_W'(2)) - v;
    if (v < $signed(IDX_W'(0))) v = $signed(IDX_W'(0));
    if (v >= ns) v = ns - $signed(IDX_W'(1));
    return v[RC_W-1:0];
  endfunction

endpackage

// File: hw/rtl/mf2d_in_if.sv
interface mf2d_in_if;
  logic                       valid;
  logic                       ready;
  logic                       cmd;
  logic [mf2d_pkg::PIX_W-1:0] pixel;

  modport source(output valid, cmd, pixel, input ready);
  modport sink(input valid, cmd, pixel, output ready);
endinterface

// File: hw/rtl/mf2d_out_if.sv
interface mf2d_out_if;
  logic                       valid;
  logic                       ready;
  logic [mf2d_pkg::PIX_W-1:0] median;
  logic                       row_end;
  logic                       frame_end;
  logic                       last_of_item;

  modport source(output valid, median, row_end, frame_end, last_of_item, input ready);
  modport sink(input valid, median, row_end, frame_end, last_of_item, output ready);
endinterface

// File: hw/rtl/median_filter_2d.sv
// channel | dir | payload                                 | handshake
// in_ch   | in  | cmd, pixel                              | valid/ready
// out_ch  | out | median, row_end, frame_end, last_of_item | valid/ready
// cfg     | in  | cfg_index, cfg_data                     | cfg_we, no wait
//
// an item with no result leaves the sequencer idle and ready; an item with
// results holds in_ch not ready until its last result is loaded; each result scans
// a window of (2*radius_x+1)*(2*radius_y+1) pixels, one line store read per window pixel
// reset is synchronous; line store contents are not cleared
// a stalled result holds the sequencer in its output step
`include "median_filter_2d_macros.svh"

module median_filter_2d (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [mf2d_pkg::CFGI_W-1:0] cfg_index,
  input  logic [mf2d_pkg::CFG_W-1:0]  cfg_data,
  mf2d_in_if.sink                     in_ch,
  mf2d_out_if.source                  out_ch
);

  localparam int RC_W   = mf2d_pkg::RC_W;
  localparam int COLS_W = mf2d_pkg::COLS_W;
  localparam int SLOT_W = mf2d_pkg::SLOT_W;
  localparam int IDX_W  = mf2d_pkg::IDX_W;
  localparam int OFF_W  = mf2d_pkg::SLOT_W;

  logic [mf2d_pkg::RAD_W-1:0]  radius_x_r, radius_y_r;
  logic [COLS_W-1:0]           image_cols_r;
  logic [mf2d_pkg::ROWS_W-1:0] image_rows_r;

  logic [mf2d_pkg::RAD_W-1:0]  rx, ry;
  logic [COLS_W-1:0]           cols;
  logic [RC_W-1:0]             rows;

  mf2d_pkg::state_t state_r, state_nxt;

  logic [RC_W-1:0]   row_count_r;
  logic [COLS_W-1:0] col_count_r;
  logic [SLOT_W-1:0] row_slot_r;

  logic [RC_W-1:0]   rc_a, rc_n;
  logic [COLS_W-1:0] cc_a, cc_n, first_a, last_a;
  logic [SLOT_W-1:0] slot_a, slot_n;
  logic              skip, have;

  logic [COLS_W-1:0] cur_x_r, last_x_r;
  logic [RC_W-1:0]   orow_r, rcur_r;
  logic [SLOT_W-1:0] wslot_r;
  logic [OFF_W-1:0]  dr_r, dc_r;
  logic              ins_r;

  logic              accept, wr, load, scan_last, start;
  mf2d_pkg::sort_ctl_t sctl;

  logic signed [IDX_W-1:0] ri, cj;
  logic [RC_W-1:0]         sr, sc;
  logic [OFF_W-1:0]        k;
  logic [SLOT_W:0]         slot_w;
  logic [SLOT_W-1:0]       rslot;
  logic [mf2d_pkg::PIX_W-1:0]  rdata, med;
  logic [mf2d_pkg::CELL_W-1:0] sel;

  logic                       out_valid_r;
  logic [mf2d_pkg::PIX_W-1:0] median_r;
  logic                       row_end_r, frame_end_r, last_r;

  // effective configuration
  always_comb begin
    rx   = (32'(radius_x_r) > mf2d_pkg::MAX_RADIUS) ?
           mf2d_pkg::RAD_W'(mf2d_pkg::MAX_RADIUS) : radius_x_r;
    ry   = (32'(radius_y_r) > mf2d_pkg::MAX_RADIUS) ?
           mf2d_pkg::RAD_W'(mf2d_pkg::MAX_RADIUS) : radius_y_r;
    cols = (32'(image_cols_r) > mf2d_pkg::MAX_WIDTH) ?
           COLS_W'(mf2d_pkg::MAX_WIDTH) : image_cols_r;
    if (cols == '0) cols = COLS_W'(1);
    rows = (image_rows_r == '0) ? RC_W'(1) : RC_W'(image_rows_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_x_r   <= mf2d_pkg::RAD_W'(2);
      radius_y_r   <= mf2d_pkg::RAD_W'(2);
      image_cols_r <= COLS_W'(640);
      image_rows_r <= mf2d_pkg::ROWS_W'(480);
    end else if (cfg_we) begin
      case (mf2d_pkg::cfg_reg_t'(cfg_index))
        mf2d_pkg::CFG_RADIUS_X:   radius_x_r   <= cfg_data[mf2d_pkg::RAD_W-1:0];
        mf2d_pkg::CFG_RADIUS_Y:   radius_y_r   <= cfg_data[mf2d_pkg::RAD_W-1:0];
        mf2d_pkg::CFG_IMAGE_COLS: image_cols_r <= cfg_data[COLS_W-1:0];
        mf2d_pkg::CFG_IMAGE_ROWS: image_rows_r <= cfg_data[mf2d_pkg::ROWS_W-1:0];
        default: ;
      endcase
    end
  end

  // item decode
  always_comb begin
    rc_a    = row_count_r;
    cc_a    = col_count_r;
    slot_a  = row_slot_r;
    skip    = 1'b0;
    have    = 1'b0;
    first_a = '0;
    last_a  = '0;
    if (in_ch.cmd == mf2d_pkg::CMD_PIXEL) begin
      if (rc_a >= rows) begin
        rc_a   = '0;
        cc_a   = '0;
        slot_a = '0;
      end
    end else if ((rc_a < rows) || (rc_a >= rows + RC_W'(ry))) begin
      skip = 1'b1;
    end
    if (cc_a >= cols) cc_a = cols - COLS_W'(1);
    if (!skip && (rc_a >= RC_W'(ry))) begin
      if (cc_a >= COLS_W'(rx)) begin
        have    = 1'b1;
        first_a = cc_a - COLS_W'(rx);
        last_a  = (cc_a == cols - COLS_W'(1)) ? cols - COLS_W'(1) : first_a;
      end else if (cc_a == cols - COLS_W'(1)) begin
        have    = 1'b1;
        first_a = '0;
        last_a  = cols - COLS_W'(1);
      end
    end
    cc_n   = cc_a + COLS_W'(1);
    rc_n   = rc_a;
    slot_n = slot_a;
    if (cc_n >= cols) begin
      cc_n   = '0;
      rc_n   = rc_a + RC_W'(1);
      slot_n = (slot_a == SLOT_W'(mf2d_pkg::RING_ROWS - 1)) ? '0 : slot_a + SLOT_W'(1);
    end
  end

  assign accept    = in_ch.valid && in_ch.ready;
  assign scan_last = (dr_r == OFF_W'(2 * ry)) && (dc_r == OFF_W'(2 * rx));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mf2d_pkg::ST_IDLE:  if (accept && have) state_nxt = mf2d_pkg::ST_SCAN;
      mf2d_pkg::ST_SCAN:  if (scan_last) state_nxt = mf2d_pkg::ST_DRAIN;
      mf2d_pkg::ST_DRAIN: state_nxt = mf2d_pkg::ST_OUT;
      mf2d_pkg::ST_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          state_nxt = (cur_x_r == last_x_r) ? mf2d_pkg::ST_IDLE : mf2d_pkg::ST_SCAN;
        end
      end
      default: state_nxt = mf2d_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ch.ready = (state_r == mf2d_pkg::ST_IDLE);
    wr          = accept && (in_ch.cmd == mf2d_pkg::CMD_PIXEL);
    load        = (state_r == mf2d_pkg::ST_OUT) && (!out_valid_r || out_ch.ready);
    start       = (accept && have) || (load && (cur_x_r != last_x_r));
    sctl.clr    = start;
    sctl.ins    = ins_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mf2d_pkg::ST_IDLE;
      row_count_r <= '0;
      col_count_r <= '0;
      row_slot_r  <= '0;
      ins_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ins_r   <= (state_r == mf2d_pkg::ST_SCAN);
      if (accept && !skip) begin
        row_count_r <= rc_n;
        col_count_r <= cc_n;
        row_slot_r  <= slot_n;
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && have) begin
      cur_x_r  <= first_a;
      last_x_r <= last_a;
      orow_r   <= rc_a - RC_W'(ry);
      rcur_r   <= rc_a;
      wslot_r  <= slot_a;
    end else if (load) begin
      cur_x_r <= cur_x_r + COLS_W'(1);
    end
    if (start) begin
      dr_r <= '0;
      dc_r <= '0;
    end else if (state_r == mf2d_pkg::ST_SCAN) begin
      if (dc_r == OFF_W'(2 * rx)) begin
        dc_r <= '0;
        dr_r <= dr_r + OFF_W'(1);
      end else begin
        dc_r <= dc_r + OFF_W'(1);
      end
    end
  end

  // window address
  always_comb begin
    ri     = $signed(IDX_W'(orow_r) + IDX_W'(dr_r) - IDX_W'(ry));
    cj     = $signed(IDX_W'(cur_x_r) + IDX_W'(dc_r) - IDX_W'(rx));
    sr     = mf2d_pkg::mirror(ri, rows);
    sc     = mf2d_pkg::mirror(cj, RC_W'(cols));
    k      = OFF_W'(rcur_r - sr);
    slot_w = (wslot_r >= k) ? {1'b0, wslot_r} - {1'b0, k} :
             {1'b0, wslot_r} + (SLOT_W + 1)'(mf2d_pkg::RING_ROWS) - {1'b0, k};
    rslot  = slot_w[SLOT_W-1:0];
    sel    = mf2d_pkg::CELL_W'(2 * rx * ry + rx + ry);
  end

  mf2d_line_store u_store (
    .clk   (clk),
    .we    (wr),
    .wslot (slot_a),
    .wcol  (cc_a[mf2d_pkg::COL_W-1:0]),
    .wdata (in_ch.pixel),
    .rslot (rslot),
    .rcol  (sc[mf2d_pkg::COL_W-1:0]),
    .rdata (rdata)
  );

  mf2d_sorter u_sorter (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (sctl),
    .din   (rdata),
    .sel   (sel),
    .dout  (med)
  );

  always_ff @(posedge clk) begin
    if (load) begin
      median_r    <= med;
      row_end_r   <= (cur_x_r == cols - COLS_W'(1));
      frame_end_r <= (cur_x_r == cols - COLS_W'(1)) && (orow_r == rows - RC_W'(1));
      last_r      <= (cur_x_r == last_x_r);
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.median       = median_r;
  assign out_ch.row_end      = row_end_r;
  assign out_ch.frame_end    = frame_end_r;
  assign out_ch.last_of_item = last_r;

  `MF2D_CHECK(a_ins_busy, ins_r, (state_r == mf2d_pkg::ST_SCAN) || (state_r == mf2d_pkg::ST_DRAIN), "insert outside scan")
  `MF2D_CHECK(a_col_order, state_r != mf2d_pkg::ST_IDLE, cur_x_r <= last_x_r, "column past last")
  `MF2D_CHECK(a_clr_quiet, sctl.clr, !sctl.ins, "sorter cleared during insert")
  `MF2D_NEXT(a_load_valid, load, out_ch.valid, "result not presented")

endmodule

// File: hw/rtl/mf2d_sort_cell.sv
module mf2d_sort_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  mf2d_pkg::sort_ctl_t        ctl,
  input  logic [mf2d_pkg::PIX_W-1:0] din,
  input  logic [mf2d_pkg::PIX_W-1:0] left_val,
  input  logic                       left_vld,
  input  logic                       left_le,
  output logic [mf2d_pkg::PIX_W-1:0] val,
  output logic                       vld,
  output logic                       le
);

  logic [mf2d_pkg::PIX_W-1:0] val_r;
  logic                       vld_r;

  assign le  = vld_r && (val_r <= din);
  assign val = val_r;
  assign vld = vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ctl.clr) begin
      vld_r <= 1'b0;
    end else if (ctl.ins && !le) begin
      vld_r <= left_le ? 1'b1 : left_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ins && !le) begin
      val_r <= left_le ? din : left_val;
    end
  end

endmodule

// File: hw/rtl/mf2d_sorter.sv
module mf2d_sorter (
  input  logic                        clk,
  input  logic                        rst_n,
  input  mf2d_pkg::sort_ctl_t         ctl,
  input  logic [mf2d_pkg::PIX_W-1:0]  din,
  input  logic [mf2d_pkg::CELL_W-1:0] sel,
  output logic [mf2d_pkg::PIX_W-1:0]  dout
);

  logic [mf2d_pkg::PIX_W-1:0] val_w [mf2d_pkg::WIN_MAX];
  logic [mf2d_pkg::WIN_MAX-1:0] vld_w;
  logic [mf2d_pkg::WIN_MAX-1:0] le_w;

  for (genvar g = 0; g < mf2d_pkg::WIN_MAX; g++) begin : g_cell
    if (g == 0) begin : g_head
      mf2d_sort_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .din      (din),
        .left_val ('0),
        .left_vld (1'b0),
        .left_le  (1'b1),
        .val      (val_w[g]),
        .vld      (vld_w[g]),
        .le       (le_w[g])
      );
    end else begin : g_body
      mf2d_sort_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .din      (din),
        .left_val (val_w[g-1]),
        .left_vld (vld_w[g-1]),
        .left_le  (le_w[g-1]),
        .val      (val_w[g]),
        .vld      (vld_w[g]),
        .le       (le_w[g])
      );
    end
  end

  assign dout = val_w[sel];

endmodule

// File: hw/rtl/mf2d_line_store.sv
module mf2d_line_store (
  input  logic                        clk,
  input  logic                        we,
  input  logic [mf2d_pkg::SLOT_W-1:0] wslot,
  input  logic [mf2d_pkg::COL_W-1:0]  wcol,
  input  logic [mf2d_pkg::PIX_W-1:0]  wdata,
  input  logic [mf2d_pkg::SLOT_W-1:0] rslot,
  input  logic [mf2d_pkg::COL_W-1:0]  rcol,
  output logic [mf2d_pkg::PIX_W-1:0]  rdata
);

  logic [mf2d_pkg::PIX_W-1:0] mem [mf2d_pkg::RING_ROWS][mf2d_pkg::MAX_WIDTH];
  logic [mf2d_pkg::PIX_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wslot][wcol] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[rslot][rcol];
  end

  assign rdata = rdata_r;

endmodule
